>>> rtl/cubic_bezier_eval_and_solve_t_macros.svh
// Assertion macros for the cubic Bezier evaluate/solve block.
// Included by the top level; no other dependencies.
`ifndef CUBIC_BEZIER_EVAL_AND_SOLVE_T_MACROS_SVH
`define CUBIC_BEZIER_EVAL_AND_SOLVE_T_MACROS_SVH

`ifndef SYNTH
`define CBES_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define CBES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CBES_ASSERT_NOW(lbl, ante, cons, msg)
`define CBES_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/cbes_pkg.sv
// Shared types, constants and the lerp schedule for the cubic Bezier block.
// No dependencies.
package cbes_pkg;

  localparam int CRD_W       = 32;
  localparam int T_FRAC_BITS = 16;
  localparam int T_W         = 17;
  localparam int BISECT_CAP  = 50;
  localparam int ITER_W      = $clog2(BISECT_CAP + 1);
  localparam int N_PTS       = 4;
  localparam int STEP_W      = 4;

  localparam logic [T_W-1:0]    T_ONE  = T_W'(1) << T_FRAC_BITS;
  localparam logic [T_W-1:0]    T_HALF = T_W'(1) << (T_FRAC_BITS - 1);
  localparam logic [STEP_W-1:0] LAST_X  = STEP_W'(7);
  localparam logic [STEP_W-1:0] LAST_XY = STEP_W'(12);

  localparam logic CRD_X = 1'b0;
  localparam logic CRD_Y = 1'b1;

  localparam logic FUNC_EVAL  = 1'b0;
  localparam logic FUNC_SOLVE = 1'b1;

  typedef struct packed {
    logic       vld;
    logic       crd;
    logic [1:0] idx;
  } op_t;

  typedef struct packed {
    logic                    func;
    logic [T_W-1:0]          t_param;
    logic signed [CRD_W-1:0] x_target;
  } in_req_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] x_out;
    logic signed [CRD_W-1:0] y_out;
    logic [T_W-1:0]          t_out;
    logic                    found;
  } out_res_t;

  function automatic op_t mk_op(input logic crd, input logic [1:0] idx);
    op_t op;
    op.vld = 1'b1;
    op.crd = crd;
    op.idx = idx;
    return op;
  endfunction

  // One lerp issued per slot; its writeback follows through the lerp's register.
  // x-only: three rounds, one bubble before the last round.
  function automatic op_t op_sched(input logic xy, input logic [STEP_W-1:0] s);
    op_t op;
    op = '0;
    if (xy) begin
      case (s)
        4'd0:    op = mk_op(CRD_X, 2'd0);
        4'd1:    op = mk_op(CRD_Y, 2'd0);
        4'd2:    op = mk_op(CRD_X, 2'd1);
        4'd3:    op = mk_op(CRD_Y, 2'd1);
        4'd4:    op = mk_op(CRD_X, 2'd2);
        4'd5:    op = mk_op(CRD_Y, 2'd2);
        4'd6:    op = mk_op(CRD_X, 2'd0);
        4'd7:    op = mk_op(CRD_Y, 2'd0);
        4'd8:    op = mk_op(CRD_X, 2'd1);
        4'd9:    op = mk_op(CRD_Y, 2'd1);
        4'd10:   op = mk_op(CRD_X, 2'd0);
        4'd11:   op = mk_op(CRD_Y, 2'd0);
        default: op = '0;
      endcase
    end else begin
      case (s)
        4'd0:    op = mk_op(CRD_X, 2'd0);
        4'd1:    op = mk_op(CRD_X, 2'd1);
        4'd2:    op = mk_op(CRD_X, 2'd2);
        4'd3:    op = mk_op(CRD_X, 2'd0);
        4'd4:    op = mk_op(CRD_X, 2'd1);
        4'd6:    op = mk_op(CRD_X, 2'd0);
        default: op = '0;
      endcase
    end
    return op;
  endfunction

endpackage

>>> rtl/cbes_lerp.sv
// Shared lerp unit: a + ((t * (b - a)) >>> T_FRAC_BITS); a and the product are registered, the add is not.
// Depends on cbes_pkg.
module cbes_lerp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cbes_pkg::op_t                    issue_op,
  input  logic signed [cbes_pkg::CRD_W-1:0] a,
  input  logic signed [cbes_pkg::CRD_W-1:0] b,
  input  logic [cbes_pkg::T_W-1:0]          t,
  output cbes_pkg::op_t                    wb_op,
  output logic signed [cbes_pkg::CRD_W-1:0] wb_val
);
  import cbes_pkg::*;

  logic signed [CRD_W:0]         diff;
  logic signed [T_W:0]           t_s;
  logic signed [CRD_W+T_W+1:0]   prod;
  logic signed [CRD_W-1:0]       a_r;
  logic signed [CRD_W-1:0]       prod_r;
  op_t                           op_r;

  assign diff = $signed({b[CRD_W-1], b}) - $signed({a[CRD_W-1], a});
  assign t_s  = $signed({1'b0, t});
  assign prod = t_s * diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= '0;
    end else begin
      op_r <= issue_op;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a;
    prod_r <= prod[T_FRAC_BITS+CRD_W-1:T_FRAC_BITS];
  end

  // true result lies between a and b, so the low word is exact
  assign wb_op  = op_r;
  assign wb_val = a_r + prod_r;

endmodule

>>> rtl/cubic_bezier_eval_and_solve_t.sv
// Evaluate and end-point solve run setup, an x/y de Casteljau pass and output; a
// solve miss goes from setup straight to output. Solve by bisection: 16 rounds of
// an x-only de Casteljau pass plus a decide state, then an x/y pass. One request at a
// time, the next taken the cycle after the result is loaded; all passes share
// one 17x33 multiplier (cbes_lerp).
// Sync active-low reset: control points to 0, sequencer idle, no result held.
`include "cubic_bezier_eval_and_solve_t_macros.svh"
module cubic_bezier_eval_and_solve_t (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [2:0]                       cfg_index,
  input  logic [cbes_pkg::CRD_W-1:0]       cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  cbes_pkg::in_req_t                in_req,
  output logic                             out_valid,
  input  logic                             out_stall,
  output cbes_pkg::out_res_t               out_res
);
  import cbes_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SETUP  = 5'b00010,
    ST_EVAL   = 5'b00100,
    ST_DECIDE = 5'b01000,
    ST_OUT    = 5'b10000
  } state_t;

  state_t                  state_r;
  logic signed [CRD_W-1:0] pts_r [N_PTS][2];
  logic signed [CRD_W-1:0] w_r   [N_PTS][2];
  logic signed [CRD_W-1:0] cur   [N_PTS][2];
  logic                    func_r;
  logic                    rev_r;
  logic                    xy_r;
  logic                    found_r;
  logic signed [CRD_W-1:0] xt_r;
  logic [T_W-1:0]          t_r;
  logic [T_W-1:0]          tmin_r;
  logic [T_W-1:0]          tmax_r;
  logic [ITER_W-1:0]       iter_r;
  logic [STEP_W-1:0]       step_r;
  logic                    out_valid_r;
  out_res_t                out_res_r;

  op_t                     issue_op;
  op_t                     wb_op;
  logic signed [CRD_W-1:0] lerp_a;
  logic signed [CRD_W-1:0] lerp_b;
  logic signed [CRD_W-1:0] wb_val;
  logic [1:0]              idx_p1;
  logic [T_W-1:0]          t_sat;
  logic                    gt;
  logic [T_W-1:0]          tmin_nxt;
  logic [T_W-1:0]          tmax_nxt;
  logic [T_W-1:0]          span_nxt;
  logic [T_W-1:0]          tc_nxt;
  logic [ITER_W-1:0]       iter_nxt;
  logic                    bis_done;
  logic [STEP_W-1:0]       last_step;
  out_res_t                res_nxt;

  always_comb begin
    for (int i = 0; i < N_PTS; i++) begin
      for (int c = 0; c < 2; c++) begin
        cur[i][c] = rev_r ? pts_r[N_PTS-1-i][c] : pts_r[i][c];
      end
    end
  end

  assign issue_op = (state_r == ST_EVAL) ? op_sched(xy_r, step_r) : '0;
  assign idx_p1   = issue_op.idx + 2'd1;
  assign lerp_a   = w_r[issue_op.idx][issue_op.crd];
  assign lerp_b   = w_r[idx_p1][issue_op.crd];

  cbes_lerp u_lerp (
    .clk      (clk),
    .rst_n    (rst_n),
    .issue_op (issue_op),
    .a        (lerp_a),
    .b        (lerp_b),
    .t        (t_r),
    .wb_op    (wb_op),
    .wb_val   (wb_val)
  );

  assign t_sat     = (in_req.t_param > T_ONE) ? T_ONE : in_req.t_param;
  assign gt        = w_r[0][CRD_X] > xt_r;
  assign tmin_nxt  = gt ? tmin_r : t_r;
  assign tmax_nxt  = gt ? t_r : tmax_r;
  assign span_nxt  = tmax_nxt - tmin_nxt;
  assign tc_nxt    = tmin_nxt + (span_nxt >> 1);
  assign iter_nxt  = iter_r + ITER_W'(1);
  assign bis_done  = (span_nxt <= T_W'(1)) || (iter_nxt == ITER_W'(BISECT_CAP));
  assign last_step = xy_r ? LAST_XY : LAST_X;

  always_comb begin
    res_nxt = '0;
    if (found_r) begin
      res_nxt.x_out = w_r[0][CRD_X];
      res_nxt.y_out = w_r[0][CRD_Y];
      res_nxt.t_out = t_r;
      res_nxt.found = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < N_PTS; i++) begin
        pts_r[i][0] <= '0;
        pts_r[i][1] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        pts_r[cfg_index[2:1]][cfg_index[0]] <= cfg_wdata;
      end
      if (state_r == ST_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          if (func_r == FUNC_EVAL || (cur[0][CRD_X] <= xt_r && xt_r <= cur[N_PTS-1][CRD_X])) begin
            state_r <= ST_EVAL;
          end else begin
            state_r <= ST_OUT;
          end
        end
        ST_EVAL: begin
          if (step_r == last_step) begin
            state_r <= xy_r ? ST_OUT : ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          state_r <= ST_EVAL;
        end
        ST_OUT: begin
          if (!out_valid_r || !out_stall) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wb_op.vld) begin
      w_r[wb_op.idx][wb_op.crd] <= wb_val;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          func_r <= in_req.func;
          xt_r   <= in_req.x_target;
          t_r    <= t_sat;
          rev_r  <= (in_req.func == FUNC_SOLVE) && (pts_r[0][CRD_X] > pts_r[N_PTS-1][CRD_X]);
        end
      end
      ST_SETUP: begin
        w_r     <= cur;
        step_r  <= '0;
        xy_r    <= 1'b1;
        found_r <= 1'b1;
        if (func_r == FUNC_SOLVE) begin
          if (cur[0][CRD_X] < xt_r && xt_r < cur[N_PTS-1][CRD_X]) begin
            xy_r   <= 1'b0;
            tmin_r <= '0;
            tmax_r <= T_ONE;
            t_r    <= T_HALF;
            iter_r <= '0;
          end else if (xt_r == cur[0][CRD_X]) begin
            t_r <= '0;
          end else if (xt_r == cur[N_PTS-1][CRD_X]) begin
            t_r <= T_ONE;
          end else begin
            found_r <= 1'b0;
          end
        end
      end
      ST_EVAL: begin
        step_r <= step_r + STEP_W'(1);
      end
      ST_DECIDE: begin
        tmin_r <= tmin_nxt;
        tmax_r <= tmax_nxt;
        t_r    <= tc_nxt;
        iter_r <= iter_nxt;
        xy_r   <= bis_done;
        step_r <= '0;
        w_r    <= cur;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_res_r <= res_nxt;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  `CBES_ASSERT_NOW(a_wb_only_in_eval, state_r != ST_EVAL, !wb_op.vld, "lerp writeback outside eval pass")
  `CBES_ASSERT_NOW(a_bisect_order, state_r == ST_DECIDE, tmin_r < t_r && t_r < tmax_r, "bisection midpoint outside bounds")
  `CBES_ASSERT_NOW(a_miss_zero, out_valid && !out_res.found, out_res.t_out == '0 && out_res.x_out == '0 && out_res.y_out == '0, "miss result not zeroed")
  `CBES_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall && !out_valid_r || in_stall, "request accepted without going busy")

endmodule

>>> bench/cubic_bezier_eval_and_solve_t_tb.sv
// Testbench for cubic_bezier_eval_and_solve_t: evaluate and solve requests
// checked against a fixed-point de Casteljau predictor. Depends on cbes_pkg.
module cubic_bezier_eval_and_solve_t_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbes_pkg::*;

  localparam logic [2:0] REG_P0_X = 3'd0;
  localparam logic [2:0] REG_P0_Y = 3'd1;
  localparam logic [2:0] REG_P1_X = 3'd2;
  localparam logic [2:0] REG_P1_Y = 3'd3;
  localparam logic [2:0] REG_P2_X = 3'd4;
  localparam logic [2:0] REG_P2_Y = 3'd5;
  localparam logic [2:0] REG_P3_X = 3'd6;
  localparam logic [2:0] REG_P3_Y = 3'd7;

  localparam longint ONE_Q      = longint'(1) << T_FRAC_BITS;
  localparam int     CYCLE_CAP  = 1_000_000;
  localparam logic [31:0] CRD_MIN = 32'h8000_0000;
  localparam logic [31:0] CRD_MAX = 32'h7FFF_FFFF;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [2:0]         cfg_index;
  logic [CRD_W-1:0]   cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  in_req_t            in_req;
  logic               out_valid;
  logic               out_stall;
  out_res_t           out_res;

  longint      ctl_x[4];
  longint      ctl_y[4];
  out_res_t    pending_q[$];
  out_res_t    want;
  int          idle_pct = 33;
  int          mismatches = 0;
  int          results_seen = 0;
  int unsigned cycle_cnt = 0;

  cubic_bezier_eval_and_solve_t dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint lerp_q(input longint a, input longint b, input longint t);
    return a + ((t * (b - a)) >>> T_FRAC_BITS);
  endfunction

  function automatic void curve_at(input logic rev, input longint t,
                                   output longint x_o, output longint y_o);
    longint wx[4];
    longint wy[4];
    for (int i = 0; i < 4; i++) begin
      wx[i] = ctl_x[rev ? 3 - i : i];
      wy[i] = ctl_y[rev ? 3 - i : i];
    end
    for (int j = 3; j > 0; j--) begin
      for (int i = 0; i < j; i++) begin
        wx[i] = lerp_q(wx[i], wx[i + 1], t);
        wy[i] = lerp_q(wy[i], wy[i + 1], t);
      end
    end
    x_o = wx[0];
    y_o = wy[0];
  endfunction

  function automatic out_res_t predict_result(input in_req_t r);
    out_res_t res;
    longint   t, x, y, xt, lo, hi, tmin, tmax, tc, cx, cy;
    logic     rev, ok, done;
    t  = 0;
    x  = 0;
    y  = 0;
    ok = 1'b0;
    rev = 1'b0;
    if (r.func == FUNC_EVAL) begin
      t = longint'(r.t_param);
      if (t > ONE_Q) t = ONE_Q;
      curve_at(1'b0, t, x, y);
      ok = 1'b1;
    end else begin
      xt  = longint'($signed(r.x_target));
      rev = ctl_x[0] > ctl_x[3];
      lo  = rev ? ctl_x[3] : ctl_x[0];
      hi  = rev ? ctl_x[0] : ctl_x[3];
      if (lo < xt && xt < hi) begin
        tmin = 0;
        tmax = ONE_Q;
        tc   = ONE_Q / 2;
        done = 1'b0;
        for (int it = 0; it < BISECT_CAP && !done; it++) begin
          curve_at(rev, tc, cx, cy);
          if (tmax - tmin <= 1) done = 1'b1;
          else if (cx > xt) tmax = tc;
          else tmin = tc;
          tc = tmin + (tmax - tmin) / 2;
        end
        t  = tc;
        ok = 1'b1;
      end else if (xt == lo) begin
        t  = 0;
        ok = 1'b1;
      end else if (xt == hi) begin
        t  = ONE_Q;
        ok = 1'b1;
      end
      if (ok) curve_at(rev, t, x, y);
    end
    if (!ok) begin
      x = 0;
      y = 0;
      t = 0;
    end
    res.x_out = x[31:0];
    res.y_out = y[31:0];
    res.t_out = t[T_W-1:0];
    res.found = ok;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH result %0d: %s", $realtime, results_seen, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = pending_q.pop_front();
        if (out_res.x_out !== want.x_out)
          report_mismatch($sformatf("x_out %h want %h", out_res.x_out, want.x_out));
        if (out_res.y_out !== want.y_out)
          report_mismatch($sformatf("y_out %h want %h", out_res.y_out, want.y_out));
        if (out_res.t_out !== want.t_out)
          report_mismatch($sformatf("t_out %h want %h", out_res.t_out, want.t_out));
        if (out_res.found !== want.found)
          report_mismatch($sformatf("found %b want %b", out_res.found, want.found));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d requests outstanding",
               cycle_cnt, pending_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_req(input logic func, input logic [T_W-1:0] tp,
                          input logic [CRD_W-1:0] xt);
    in_req_t r;
    r.func     = func;
    r.t_param  = tp;
    r.x_target = xt;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
    pending_q.push_back(predict_result(r));
  endtask

  task automatic drain_pending();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_points(input logic [31:0] p0x, input logic [31:0] p0y,
                            input logic [31:0] p1x, input logic [31:0] p1y,
                            input logic [31:0] p2x, input logic [31:0] p2y,
                            input logic [31:0] p3x, input logic [31:0] p3y);
    logic [7:0][31:0] v;
    v = {p3y, p3x, p2y, p2x, p1y, p1x, p0y, p0x};
    cfg_wr_en <= 1'b1;
    for (int r = REG_P0_X; r <= REG_P3_Y; r++) begin
      cfg_index <= 3'(r);
      cfg_wdata <= v[r];
      if (r[0] == CRD_Y) ctl_y[r / 2] = longint'($signed(v[r]));
      else ctl_x[r / 2] = longint'($signed(v[r]));
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [31:0] q16(input int whole);
    return 32'(whole * 65536);
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0:       return CRD_MIN;
      1:       return CRD_MAX;
      2, 3:    return $urandom;
      default: return 32'((int'($urandom_range(200)) - 100) * 65536
                          + int'($urandom_range(65535)));
    endcase
  endfunction

  // mostly targets strictly between the end x values, so bisection runs
  function automatic logic [31:0] pick_target();
    longint lo, hi, span;
    lo   = (ctl_x[0] < ctl_x[3]) ? ctl_x[0] : ctl_x[3];
    hi   = (ctl_x[0] < ctl_x[3]) ? ctl_x[3] : ctl_x[0];
    span = hi - lo;
    case ($urandom_range(11))
      0:       return lo[31:0];
      1:       return hi[31:0];
      2:       return $urandom;
      3:       return 32'(lo - 1);
      4:       return 32'(hi + 1);
      default: begin
        if (span > 1)
          return 32'(lo + 1 + longint'({$urandom, $urandom} >> 1) % (span - 1));
        return lo[31:0];
      end
    endcase
  endfunction

  task automatic test_reset_points();
    send_req(FUNC_EVAL, T_HALF, 32'd0);
    send_req(FUNC_SOLVE, 17'd0, 32'd0);
    send_req(FUNC_SOLVE, 17'd0, 32'd1);
    drain_pending();
  endtask

  task automatic test_eval_extremes();
    set_points(CRD_MIN, CRD_MAX, CRD_MAX, CRD_MIN, CRD_MIN, 32'd0, CRD_MAX, 32'hFFFF_FFFF);
    send_req(FUNC_EVAL, 17'd0, CRD_MAX);
    send_req(FUNC_EVAL, 17'd1, CRD_MIN);
    send_req(FUNC_EVAL, T_HALF, 32'd0);
    send_req(FUNC_EVAL, T_ONE, 32'd0);
    send_req(FUNC_EVAL, T_ONE + 17'd1, 32'd0);
    send_req(FUNC_EVAL, 17'h1FFFF, 32'hFFFF_FFFF);
    send_req(FUNC_SOLVE, 17'h1FFFF, 32'd0);
    drain_pending();
  endtask

  task automatic test_solve_forward();
    set_points(q16(-10), q16(0), q16(-3), q16(20), q16(3), q16(-20), q16(10), q16(5));
    send_req(FUNC_SOLVE, 17'd0, 32'd0);
    send_req(FUNC_SOLVE, 17'd0, 32'd1);
    send_req(FUNC_SOLVE, 17'd0, q16(-10));
    send_req(FUNC_SOLVE, 17'd0, q16(10));
    send_req(FUNC_SOLVE, 17'd0, q16(-10) - 32'd1);
    send_req(FUNC_SOLVE, 17'd0, q16(10) + 32'd1);
    send_req(FUNC_SOLVE, 17'd0, CRD_MIN);
    send_req(FUNC_SOLVE, 17'd0, CRD_MAX);
    drain_pending();
  endtask

  task automatic test_solve_reversed();
    set_points(q16(12), q16(1), q16(5), q16(2), q16(-1), q16(3), q16(-8), q16(4));
    send_req(FUNC_SOLVE, 17'd0, q16(3));
    send_req(FUNC_SOLVE, 17'd0, q16(12));
    send_req(FUNC_SOLVE, 17'd0, q16(-8));
    send_req(FUNC_SOLVE, 17'd0, q16(13));
    send_req(FUNC_EVAL, T_HALF, q16(3));
    drain_pending();
  endtask

  task automatic test_random_curves();
    for (int ph = 0; ph < 9; ph++) begin
      idle_pct = (ph == 4) ? 0 : 33;
      set_points(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_coord(), rand_coord());
      for (int k = 0; k < 50; k++) begin
        if ($urandom_range(1))
          send_req(FUNC_SOLVE, 17'($urandom), pick_target());
        else
          send_req(FUNC_EVAL,
                   ($urandom_range(7) == 0) ? 17'($urandom) : 17'($urandom_range(65536)),
                   $urandom);
        if ($urandom_range(63) == 0) drain_pending();
      end
      drain_pending();
    end
    idle_pct = 33;
  endtask

  initial begin
    rst_n     <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_P0_X;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_req    <= '0;
    out_stall <= 1'b0;
    for (int i = 0; i < 4; i++) begin
      ctl_x[i] = 0;
      ctl_y[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_reset_points();
    test_eval_extremes();
    test_solve_forward();
    test_solve_reversed();
    test_random_curves();

    drain_pending();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
